FILE: src/rbi_pkg.sv
`timescale 1ns / 1ps

package rbi_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int NUM_W     = COORD_W + 1;
  localparam int DIV_STEPS = NUM_W + FRAC_W;
  localparam int QMAG_W    = COORD_W - 1;
  localparam int PROD_W    = QMAG_W + COORD_W;
  localparam int OFS_W     = COORD_W + 2;
  localparam int CHK_W     = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;

  // per-item data that rides alongside the division
  typedef struct packed {
    logic [2:0][COORD_W-1:0] o;
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][COORD_W-1:0] hi;
    logic [2:0][COORD_W-1:0] dmag;
    logic [2:0]              dneg;
    logic [2:0]              cand;
    logic [2:0]              neg;
    logic                    all_in;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0]   rem;
    logic [DIV_STEPS-1:0] dq;
  } div_lane_t;

  // one restoring step: bring in the next dividend bit, shift a quotient bit in
  function automatic div_lane_t div_step(div_lane_t cur, logic [COORD_W-1:0] den);
    logic [COORD_W:0] trial;
    div_lane_t        res;
    trial  = {cur.rem, cur.dq[DIV_STEPS-1]};
    res.dq = {cur.dq[DIV_STEPS-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      trial     = trial - {1'b0, den};
      res.dq[0] = 1'b1;
    end
    res.rem = trial[COORD_W-1:0];
    return res;
  endfunction

endpackage

FILE: src/ray_box_intersection_test.sv
`timescale 1ns / 1ps
// pipeline: stages 1 and 2 (setup), the divider, stages 3 to 7 (finish)
// one item per cycle unless the output stalls; 49 one-bit divider stages set the depth
// a stalled output freezes the whole pipeline, so no item is lost or repeated
// reset: synchronous, active high; clears every stage valid bit, payload is left as is
module ray_box_intersection_test (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rbi_pkg::coord_t         origin_x,
  input  rbi_pkg::coord_t         origin_y,
  input  rbi_pkg::coord_t         origin_z,
  input  rbi_pkg::coord_t         dir_x,
  input  rbi_pkg::coord_t         dir_y,
  input  rbi_pkg::coord_t         dir_z,
  input  rbi_pkg::coord_t         box_lo_x,
  input  rbi_pkg::coord_t         box_lo_y,
  input  rbi_pkg::coord_t         box_lo_z,
  input  rbi_pkg::coord_t         box_hi_x,
  input  rbi_pkg::coord_t         box_hi_y,
  input  rbi_pkg::coord_t         box_hi_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit
);
  import rbi_pkg::*;

  // global advance: everything moves unless a result is held by the sink
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: registered inputs
  logic                    v1;
  logic [2:0][COORD_W-1:0] o1, d1, lo1, hi1;

  // stage 2: slab classification and division operands
  logic                    v2;
  side_t                   side2;
  logic [2:0][NUM_W-1:0]   num2;

  // divider outputs
  logic                    vd;
  side_t                   sided;
  logic [2:0][QMAG_W-1:0]  quot;

  // stage 3: signed ray parameters
  logic                    v3;
  side_t                   side3;
  logic [2:0][COORD_W-1:0] t3;

  // stage 4: chosen plane
  logic                    v4;
  side_t                   side4;
  logic [1:0]              best4;
  logic [COORD_W-1:0]      tb4;
  logic                    miss4;

  // stage 5: products
  logic                    v5;
  side_t                   side5;
  logic [1:0]              best5;
  logic                    miss5;
  logic [2:0][PROD_W-1:0]  prod5;

  // stage 6: hit point coordinates
  logic                    v6;
  side_t                   side6;
  logic [1:0]              best6;
  logic                    miss6;
  logic [2:0][CHK_W-1:0]   c6;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= vd;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      o1  <= {origin_z, origin_y, origin_x};
      d1  <= {dir_z, dir_y, dir_x};
      lo1 <= {box_lo_z, box_lo_y, box_lo_x};
      hi1 <= {box_hi_z, box_hi_y, box_hi_x};
    end
  end

  // stage 2: below lo is tested first, then above hi
  side_t                 side2_next;
  logic [2:0][NUM_W-1:0] num2_next;

  always_comb begin
    logic                    below, above;
    logic signed [NUM_W-1:0] diff;
    side2_next.o      = o1;
    side2_next.lo     = lo1;
    side2_next.hi     = hi1;
    side2_next.all_in = 1'b1;
    for (int a = 0; a < 3; a++) begin
      below = $signed(o1[a]) < $signed(lo1[a]);
      above = !below && ($signed(o1[a]) > $signed(hi1[a]));
      if (below) begin
        diff = $signed({lo1[a][COORD_W-1], lo1[a]}) - $signed({o1[a][COORD_W-1], o1[a]});
      end else begin
        diff = $signed({hi1[a][COORD_W-1], hi1[a]}) - $signed({o1[a][COORD_W-1], o1[a]});
      end
      num2_next[a]        = diff[NUM_W-1] ? NUM_W'(-diff) : NUM_W'(diff);
      side2_next.dneg[a]  = d1[a][COORD_W-1];
      side2_next.dmag[a]  = d1[a][COORD_W-1] ? -d1[a] : d1[a];
      side2_next.neg[a]   = diff[NUM_W-1] ^ d1[a][COORD_W-1];
      side2_next.cand[a]  = (below || above) && (d1[a] != '0);
      if (below || above) begin
        side2_next.all_in = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side2_next;
      num2  <= num2_next;
    end
  end

  rbi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_side   (side2),
    .num       (num2),
    .out_valid (vd),
    .out_side  (sided),
    .quot      (quot)
  );

  // stage 3: non-candidate axes take minus one
  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= sided;
      for (int a = 0; a < 3; a++) begin
        if (!sided.cand[a]) begin
          t3[a] <= -(COORD_W'(1) << FRAC_W);
        end else if (sided.neg[a]) begin
          t3[a] <= -{1'b0, quot[a]};
        end else begin
          t3[a] <= {1'b0, quot[a]};
        end
      end
    end
  end

  // stage 4: largest t, lowest axis wins ties
  logic [1:0]         best_next;
  logic [COORD_W-1:0] tb_next;

  always_comb begin
    best_next = 2'd0;
    tb_next   = t3[0];
    if ($signed(tb_next) < $signed(t3[1])) begin
      best_next = 2'd1;
      tb_next   = t3[1];
    end
    if ($signed(tb_next) < $signed(t3[2])) begin
      best_next = 2'd2;
      tb_next   = t3[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side3;
      best4 <= best_next;
      tb4   <= tb_next;
      miss4 <= tb_next[COORD_W-1];
    end
  end

  // stage 5: t times direction magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= side4;
      best5 <= best4;
      miss5 <= miss4;
      for (int a = 0; a < 3; a++) begin
        prod5[a] <= tb4[QMAG_W-1:0] * side4.dmag[a];
      end
    end
  end

  // stage 6: scale, saturate, step along the ray
  always_ff @(posedge clk) begin
    if (en) begin
      logic [PROD_W-FRAC_W-1:0] sh;
      logic [OFS_W-1:0]         ofs;
      side6 <= side5;
      best6 <= best5;
      miss6 <= miss5;
      for (int a = 0; a < 3; a++) begin
        sh = prod5[a][PROD_W-1:FRAC_W];
        if (sh > (PROD_W-FRAC_W)'(1) << (COORD_W+1)) begin
          ofs = OFS_W'(1) << (COORD_W+1);
        end else begin
          ofs = sh[OFS_W-1:0];
        end
        if (side5.dneg[a]) begin
          c6[a] <= CHK_W'($signed(side5.o[a])) - CHK_W'({1'b0, ofs});
        end else begin
          c6[a] <= CHK_W'($signed(side5.o[a])) + CHK_W'({1'b0, ofs});
        end
      end
    end
  end

  // stage 7: bounds check on the two other axes
  logic hit_next;

  always_comb begin
    logic ok;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (2'(a) != best6) begin
        if ($signed(c6[a]) < $signed(CHK_W'($signed(side6.lo[a]))) ||
            $signed(c6[a]) > $signed(CHK_W'($signed(side6.hi[a])))) begin
          ok = 1'b0;
        end
      end
    end
    hit_next = side6.all_in || (!miss6 && ok);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

  // the input side stalls exactly when a held result blocks the pipeline
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the blocked output");

  // an origin inside the box always leaves as a hit
  a_inside_hit: assert property (@(posedge clk) disable iff (rst)
    (v6 && side6.all_in && en) |=> (out_valid && hit))
    else $error("inside origin not reported as a hit");

  // a miss flagged at plane choice can only turn into a hit through the inside case
  a_miss_path: assert property (@(posedge clk) disable iff (rst)
    (v6 && miss6 && !side6.all_in && en) |=> !hit)
    else $error("negative largest t reported as a hit");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit)))
    else $error("stalled result changed");

endmodule

FILE: src/rbi_div.sv
`timescale 1ns / 1ps

module rbi_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  rbi_pkg::side_t                      in_side,
  input  logic [2:0][rbi_pkg::NUM_W-1:0]      num,
  output logic                                out_valid,
  output rbi_pkg::side_t                      out_side,
  output logic [2:0][rbi_pkg::QMAG_W-1:0]     quot
);
  import rbi_pkg::*;

  logic                  vld  [DIV_STEPS];
  side_t                 side [DIV_STEPS];
  div_lane_t [2:0]       lane [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic            v_cur;
    side_t           s_cur;
    div_lane_t [2:0] l_cur;
    if (k == 0) begin : g_first
      assign v_cur = in_valid;
      assign s_cur = in_side;
      for (genvar a = 0; a < 3; a++) begin : g_ax
        assign l_cur[a].rem = '0;
        assign l_cur[a].dq  = {num[a], {FRAC_W{1'b0}}};
      end
    end else begin : g_rest
      assign v_cur = vld[k-1];
      assign s_cur = side[k-1];
      assign l_cur = lane[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= s_cur;
        for (int a = 0; a < 3; a++) begin
          lane[k][a] <= div_step(l_cur[a], s_cur.dmag[a]);
        end
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_side  = side[DIV_STEPS-1];

  // saturate the quotient magnitude
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (lane[DIV_STEPS-1][a].dq[DIV_STEPS-1:QMAG_W] != '0) begin
        quot[a] = '1;
      end else begin
        quot[a] = lane[DIV_STEPS-1][a].dq[QMAG_W-1:0];
      end
    end
  end

endmodule
